### src/tcpq_pkg.sv
package tcpq_pkg;

	localparam int VAL_W = 32;

	typedef logic [1:0]              cmd_t;
	typedef logic [1:0]              status_t;
	typedef logic signed [VAL_W-1:0] val_t;

	localparam cmd_t CMD_PUSH  = 2'd0;
	localparam cmd_t CMD_POP   = 2'd1;
	localparam cmd_t CMD_CLEAR = 2'd2;

	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_FULL  = 2'd1;
	localparam status_t ST_EMPTY = 2'd2;

	typedef struct packed {
		logic exec;
		logic fill;
		logic load_out;
	} tcpq_cmd_t;

	typedef struct packed {
		logic fetch_needed;
	} tcpq_stat_t;

endpackage

### src/tcpq_if.sv
interface tcpq_req_if;
	import tcpq_pkg::*;

	logic  valid;
	logic  ready;
	cmd_t  command;
	val_t  value;

	modport source (output valid, output command, output value, input ready);
	modport sink   (input valid, input command, input value, output ready);
endinterface

interface tcpq_rsp_if #(
	parameter int CW = 5
);
	import tcpq_pkg::*;

	logic          valid;
	logic          ready;
	status_t       status;
	val_t          popped_value;
	val_t          front_value;
	val_t          tail_value;
	val_t          last_priority_value;
	logic          has_priority;
	logic [CW-1:0] item_count;

	modport source (
		output valid, output status, output popped_value, output front_value,
		output tail_value, output last_priority_value, output has_priority,
		output item_count, input ready
	);
	modport sink (
		input valid, input status, input popped_value, input front_value,
		input tail_value, input last_priority_value, input has_priority,
		input item_count, output ready
	);
endinterface

interface tcpq_cfg_if;
	import tcpq_pkg::*;

	logic  valid;
	logic  ready;
	val_t  priority_threshold;

	modport source (output valid, output priority_threshold, input ready);
	modport sink   (input valid, input priority_threshold, output ready);
endinterface

### src/tcpq_ram.sv
module tcpq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

### src/tcpq_ctrl.sv
module tcpq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  tcpq_pkg::tcpq_stat_t stat,
	output tcpq_pkg::tcpq_cmd_t  cmd
);
	import tcpq_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_FILL = 2'd1;
	localparam logic [1:0] S_EMIT = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;
	logic       slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d      = state_q;
		cmd.exec     = 1'b0;
		cmd.fill     = 1'b0;
		cmd.load_out = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.exec = 1'b1;
					state_d  = stat.fetch_needed ? S_FILL : S_EMIT;
				end
			end
			S_FILL: begin
				cmd.fill = 1'b1;
				state_d  = S_EMIT;
			end
			S_EMIT: begin
				if (slot_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end
endmodule

### src/tcpq_dp.sv
module tcpq_dp #(
	parameter int DEPTH = 16,
	parameter int AW    = $clog2(DEPTH),
	parameter int CW    = $clog2(DEPTH + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tcpq_pkg::tcpq_cmd_t  cmd,
	output tcpq_pkg::tcpq_stat_t stat,
	input  tcpq_pkg::cmd_t       command,
	input  tcpq_pkg::val_t       value,
	input  logic                 thr_we,
	input  tcpq_pkg::val_t       thr_wdata,
	output tcpq_pkg::status_t    status,
	output tcpq_pkg::val_t       popped_value,
	output tcpq_pkg::val_t       front_value,
	output tcpq_pkg::val_t       tail_value,
	output tcpq_pkg::val_t       last_priority_value,
	output logic                 has_priority,
	output logic [CW-1:0]        item_count
);
	import tcpq_pkg::*;

	localparam logic [AW:0]   DEPTH_W = (AW+1)'(DEPTH);
	localparam logic [AW-1:0] LAST_IX = AW'(DEPTH - 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
	localparam logic [CW-1:0] ONE_C   = CW'(1);
	localparam logic [CW-1:0] TWO_C   = CW'(2);

	val_t          thr_q;
	logic [AW-1:0] phead_q, nhead_q;
	logic [CW-1:0] pcount_q, ncount_q;
	val_t          pfront_q, nfront_q, plast_q, ntail_q;
	status_t       status_q;
	val_t          popped_q;
	logic          fill_pri_q;

	logic [CW-1:0] total;
	logic          full, is_pri, pop_pri, pop_nor, p_any, n_any;
	logic [AW:0]   psum, nsum;
	logic [AW-1:0] pwaddr, nwaddr, pinc, ninc;
	logic          p_we, n_we, p_re, n_re;
	val_t          p_rdata, n_rdata;
	val_t          view_front, view_lastp, view_tail;

	assign p_any   = (pcount_q != '0);
	assign n_any   = (ncount_q != '0);
	assign total   = pcount_q + ncount_q;
	assign full    = (total == DEPTH_C);
	assign is_pri  = (value > thr_q);
	assign pop_pri = p_any;
	assign pop_nor = !p_any && n_any;

	assign psum   = {1'b0, phead_q} + {1'b0, pcount_q[AW-1:0]};
	assign nsum   = {1'b0, nhead_q} + {1'b0, ncount_q[AW-1:0]};
	assign pwaddr = (psum >= DEPTH_W) ? AW'(psum - DEPTH_W) : psum[AW-1:0];
	assign nwaddr = (nsum >= DEPTH_W) ? AW'(nsum - DEPTH_W) : nsum[AW-1:0];
	assign pinc   = (phead_q == LAST_IX) ? '0 : phead_q + AW'(1);
	assign ninc   = (nhead_q == LAST_IX) ? '0 : nhead_q + AW'(1);

	assign p_we = cmd.exec && (command == CMD_PUSH) && !full && is_pri;
	assign n_we = cmd.exec && (command == CMD_PUSH) && !full && !is_pri;
	assign p_re = cmd.exec && (command == CMD_POP) && pop_pri;
	assign n_re = cmd.exec && (command == CMD_POP) && pop_nor;

	assign stat.fetch_needed = (command == CMD_POP) &&
		((pop_pri && pcount_q >= TWO_C) || (pop_nor && ncount_q >= TWO_C));

	tcpq_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_pri_ram (
		.clk   (clk),
		.we    (p_we),
		.waddr (pwaddr),
		.wdata (value),
		.re    (p_re),
		.raddr (pinc),
		.rdata (p_rdata)
	);

	tcpq_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_nor_ram (
		.clk   (clk),
		.we    (n_we),
		.waddr (nwaddr),
		.wdata (value),
		.re    (n_re),
		.raddr (ninc),
		.rdata (n_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q    <= '0;
			phead_q  <= '0;
			nhead_q  <= '0;
			pcount_q <= '0;
			ncount_q <= '0;
		end else begin
			if (thr_we) begin
				thr_q <= thr_wdata;
			end
			if (cmd.exec) begin
				case (command)
					CMD_PUSH: begin
						if (!full && is_pri) begin
							pcount_q <= pcount_q + ONE_C;
						end else if (!full) begin
							ncount_q <= ncount_q + ONE_C;
						end
					end
					CMD_POP: begin
						if (pop_pri) begin
							phead_q  <= pinc;
							pcount_q <= pcount_q - ONE_C;
						end else if (pop_nor) begin
							nhead_q  <= ninc;
							ncount_q <= ncount_q - ONE_C;
						end
					end
					CMD_CLEAR: begin
						phead_q  <= '0;
						nhead_q  <= '0;
						pcount_q <= '0;
						ncount_q <= '0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			status_q <= ST_OK;
			popped_q <= '0;
			case (command)
				CMD_PUSH: begin
					if (full) begin
						status_q <= ST_FULL;
					end else if (is_pri) begin
						plast_q <= value;
						if (!p_any) begin
							pfront_q <= value;
						end
					end else begin
						ntail_q <= value;
						if (!n_any) begin
							nfront_q <= value;
						end
					end
				end
				CMD_POP: begin
					fill_pri_q <= pop_pri;
					if (pop_pri) begin
						popped_q <= pfront_q;
					end else if (pop_nor) begin
						popped_q <= nfront_q;
					end else begin
						status_q <= ST_EMPTY;
					end
				end
				default: begin
				end
			endcase
		end
		if (cmd.fill) begin
			if (fill_pri_q) begin
				pfront_q <= p_rdata;
			end else begin
				nfront_q <= n_rdata;
			end
		end
	end

	assign view_front = p_any ? pfront_q : (n_any ? nfront_q : '0);
	assign view_lastp = p_any ? plast_q : '0;
	assign view_tail  = n_any ? ntail_q : view_lastp;

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			status              <= status_q;
			popped_value        <= popped_q;
			front_value         <= view_front;
			tail_value          <= view_tail;
			last_priority_value <= view_lastp;
			has_priority        <= p_any;
			item_count          <= total;
		end
	end
endmodule

### src/two_class_priority_queue.sv
// channel  role    handshake      payload
// req      sink    valid/ready    command, value
// rsp      source  valid/ready    status, popped_value, front_value, tail_value,
//                                 last_priority_value, has_priority, item_count
// cfg      sink    valid/ready    priority_threshold (ready held high)
//
// One transaction on req gives one transaction on rsp. A command goes from S_IDLE to
// S_EMIT, by way of S_FILL for a pop that leaves one or more values in its class: the
// new front is read back from that class's store, whose read is registered.
// req is taken only between commands; a result waiting on rsp stalls the next
// result, not the next command.
// arst_n empties both classes and sets the threshold to 0; stores are not cleared.
module two_class_priority_queue #(
	parameter int DEPTH = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	tcpq_req_if.sink     req,
	tcpq_rsp_if.source   rsp,
	tcpq_cfg_if.sink     cfg
);
	import tcpq_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	tcpq_cmd_t  cmd;
	tcpq_stat_t stat;

	assign cfg.ready = 1'b1;

	tcpq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	tcpq_dp #(.DEPTH(DEPTH), .AW(AW), .CW(CW)) u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (cmd),
		.stat                (stat),
		.command             (req.command),
		.value               (req.value),
		.thr_we              (cfg.valid),
		.thr_wdata           (cfg.priority_threshold),
		.status              (rsp.status),
		.popped_value        (rsp.popped_value),
		.front_value         (rsp.front_value),
		.tail_value          (rsp.tail_value),
		.last_priority_value (rsp.last_priority_value),
		.has_priority        (rsp.has_priority),
		.item_count          (rsp.item_count)
	);
endmodule

### tb/two_class_priority_queue_tb.sv
module two_class_priority_queue_tb;
	import tcpq_pkg::*;

	localparam int   ENTRIES     = 16;
	localparam int   STALL_LIMIT = 4000;
	localparam int   PHASES      = 8;
	localparam int   PHASE_ITEMS = 234;
	localparam cmd_t CMD_UNUSED  = 2'd3;
	localparam val_t VAL_MAX     = 32'h7fffffff;
	localparam val_t VAL_MIN     = 32'h80000000;

	typedef struct {
		status_t    status;
		val_t       popped;
		val_t       front;
		val_t       tail;
		val_t       last_prio;
		logic       has_prio;
		logic [4:0] count;
	} queue_view_t;

	class queue_tracker;
		val_t        threshold;
		val_t        prio_ring[ENTRIES];
		val_t        norm_ring[ENTRIES];
		int          prio_head;
		int          prio_held;
		int          norm_head;
		int          norm_held;
		queue_view_t expected_views[$];
		int          results;
		int          mismatches;
		int          pushes;
		int          pops;
		int          clears;
		int          unused_codes;
		int          full_pushes;
		int          empty_pops;

		function new();
			threshold = '0;
			prio_head = 0;
			prio_held = 0;
			norm_head = 0;
			norm_held = 0;
			results = 0;
			mismatches = 0;
			pushes = 0;
			pops = 0;
			clears = 0;
			unused_codes = 0;
			full_pushes = 0;
			empty_pops = 0;
		endfunction

		function int pending();
			return expected_views.size();
		endfunction

		function void note_command(cmd_t cmd, val_t value);
			queue_view_t v;
			v.status = ST_OK;
			v.popped = '0;
			v.front = '0;
			v.tail = '0;
			v.last_prio = '0;
			case (cmd)
			CMD_PUSH: begin
				pushes++;
				if (prio_held + norm_held >= ENTRIES) begin
					v.status = ST_FULL;
					full_pushes++;
				end else if (value > threshold) begin
					prio_ring[(prio_head + prio_held) % ENTRIES] = value;
					prio_held++;
				end else begin
					norm_ring[(norm_head + norm_held) % ENTRIES] = value;
					norm_held++;
				end
			end
			CMD_POP: begin
				pops++;
				if (prio_held > 0) begin
					v.popped = prio_ring[prio_head];
					prio_head = (prio_head + 1) % ENTRIES;
					prio_held--;
				end else if (norm_held > 0) begin
					v.popped = norm_ring[norm_head];
					norm_head = (norm_head + 1) % ENTRIES;
					norm_held--;
				end else begin
					v.status = ST_EMPTY;
					empty_pops++;
				end
			end
			CMD_CLEAR: begin
				clears++;
				prio_head = 0;
				prio_held = 0;
				norm_head = 0;
				norm_held = 0;
			end
			default: begin
				unused_codes++;
			end
			endcase
			if (prio_held > 0) begin
				v.front = prio_ring[prio_head];
				v.last_prio = prio_ring[(prio_head + prio_held - 1) % ENTRIES];
			end else if (norm_held > 0) begin
				v.front = norm_ring[norm_head];
			end
			if (norm_held > 0)
				v.tail = norm_ring[(norm_head + norm_held - 1) % ENTRIES];
			else if (prio_held > 0)
				v.tail = v.last_prio;
			v.has_prio = (prio_held > 0);
			v.count = 5'(prio_held + norm_held);
			expected_views.push_back(v);
		endfunction

		function void flag(string field, logic [31:0] want, logic [31:0] got);
			mismatches++;
			if (mismatches <= 10)
				$display("result %0d: %s expected %h got %h", results, field, want, got);
		endfunction

		function void check_result(status_t status, val_t popped, val_t front, val_t tail,
				val_t last_prio, logic has_prio, logic [4:0] count);
			queue_view_t e;
			results++;
			if (expected_views.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result %0d arrived with no command outstanding", results);
				return;
			end
			e = expected_views.pop_front();
			if (status !== e.status)
				flag("status", 32'(e.status), 32'(status));
			if (popped !== e.popped)
				flag("popped_value", e.popped, popped);
			if (front !== e.front)
				flag("front_value", e.front, front);
			if (tail !== e.tail)
				flag("tail_value", e.tail, tail);
			if (last_prio !== e.last_prio)
				flag("last_priority_value", e.last_prio, last_prio);
			if (has_prio !== e.has_prio)
				flag("has_priority", 32'(e.has_prio), 32'(has_prio));
			if (count !== e.count)
				flag("item_count", 32'(e.count), 32'(count));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	tcpq_req_if           req_ch();
	tcpq_rsp_if #(.CW(5)) rsp_ch();
	tcpq_cfg_if           cfg_ch();

	queue_tracker tracker = new();
	int           hold_left = 0;
	bit           steady = 1'b0;
	int           stall_cycles = 0;
	int           settings_used = 0;

	two_class_priority_queue #(
		.DEPTH(ENTRIES)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg(cfg_ch)
	);

	always #5 clk = ~clk;

	initial begin
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				rsp_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				rsp_ch.ready <= steady || ($urandom_range(0, 99) >= 21);
			end
		end
	end

	always @(posedge clk) begin
		if (rsp_ch.valid && rsp_ch.ready)
			tracker.check_result(rsp_ch.status, rsp_ch.popped_value, rsp_ch.front_value,
				rsp_ch.tail_value, rsp_ch.last_priority_value, rsp_ch.has_priority,
				rsp_ch.item_count);
		if (req_ch.valid && req_ch.ready)
			tracker.note_command(req_ch.command, req_ch.value);
		if ((rsp_ch.valid && rsp_ch.ready) || (req_ch.valid && req_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("no transaction for %0d cycles", STALL_LIMIT);
			$display("two_class_priority_queue: mismatch");
			$finish;
		end
	end

	// call at a falling edge; returns at the falling edge after the transaction
	task automatic send_command(cmd_t cmd, val_t value);
		while (!steady && $urandom_range(0, 99) < 21) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.command <= cmd;
		req_ch.value <= value;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic await_results();
		if (tracker.pending() > 0) begin
			req_ch.valid <= 1'b0;
			while (tracker.pending() > 0)
				@(negedge clk);
		end
	endtask

	task automatic write_threshold(val_t thr);
		cfg_ch.valid <= 1'b1;
		cfg_ch.priority_threshold <= thr;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		tracker.threshold = thr;
		settings_used++;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	function automatic val_t pick_value(val_t thr);
		case ($urandom_range(0, 5))
		0: return thr;
		1: return thr + val_t'($urandom_range(0, 8)) - val_t'(4);
		2: return val_t'($urandom_range(0, 400)) - val_t'(200);
		3: return $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
		default: return val_t'($urandom);
		endcase
	endfunction

	task automatic run_mix(int items);
		int   sent;
		int   push_pct;
		int   r;
		cmd_t cmd;
		sent = 0;
		push_pct = 50;
		while (sent < items) begin
			if (sent % 40 == 0)
				push_pct = $urandom_range(15, 90);
			r = $urandom_range(0, 99);
			if (r < 2)
				cmd = CMD_UNUSED;
			else if (r < 5)
				cmd = CMD_CLEAR;
			else if (r < 5 + push_pct)
				cmd = CMD_PUSH;
			else
				cmd = CMD_POP;
			send_command(cmd, pick_value(tracker.threshold));
			if (cmd != CMD_UNUSED)
				sent++;
			if ($urandom_range(0, 199) == 0)
				await_results();
		end
	endtask

	initial begin
		int   i;
		int   phase;
		val_t thr;
		req_ch.valid = 1'b0;
		req_ch.command = CMD_PUSH;
		req_ch.value = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.priority_threshold = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_command(CMD_POP, '0);
		send_command(CMD_CLEAR, '0);
		send_command(CMD_UNUSED, 32'hffffffff);
		send_command(CMD_PUSH, '0);
		send_command(CMD_PUSH, 32'd1);
		send_command(CMD_PUSH, VAL_MAX);
		send_command(CMD_PUSH, VAL_MIN);
		send_command(CMD_PUSH, -32'sd1);
		send_command(CMD_UNUSED, '0);
		send_command(CMD_POP, '0);
		send_command(CMD_POP, '0);
		send_command(CMD_PUSH, 32'd5);
		for (i = 0; i < 12; i++)
			send_command(CMD_PUSH, (i % 2) ? val_t'(i) : -val_t'(i));
		send_command(CMD_PUSH, 32'd9);
		send_command(CMD_POP, '0);
		send_command(CMD_CLEAR, '0);

		for (phase = 0; phase < PHASES; phase++) begin
			await_results();
			case (phase)
			0: thr = VAL_MAX;
			1: thr = VAL_MIN;
			2: thr = val_t'($urandom);
			3: thr = val_t'($urandom_range(0, 40)) - val_t'(20);
			4: thr = '0;
			5: thr = val_t'($urandom);
			6: thr = -32'sd1;
			default: thr = val_t'($urandom_range(0, 400)) - val_t'(200);
			endcase
			write_threshold(thr);
			// hold the result side off while commands keep coming
			if (phase == 4)
				hold_left = 300;
			steady = (phase == 5);
			run_mix(PHASE_ITEMS);
		end

		await_results();
		repeat (16) @(posedge clk);
		$display("%0d commands: %0d push, %0d pop, %0d clear, %0d unused code; %0d thresholds",
			tracker.pushes + tracker.pops + tracker.clears + tracker.unused_codes,
			tracker.pushes, tracker.pops, tracker.clears, tracker.unused_codes, settings_used);
		$display("%0d results checked, %0d pushes refused as full, %0d pops on empty",
			tracker.results, tracker.full_pushes, tracker.empty_pops);
		if (tracker.mismatches == 0 && tracker.pending() == 0)
			$display("two_class_priority_queue: match");
		else
			$display("two_class_priority_queue: mismatch");
		$finish;
	end

endmodule
